// ----- design/jsu_pkg.sv -----
package jsu_pkg;

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_ESC    = 3'd1,
        MODE_HEX0   = 3'd2,
        MODE_HEX1   = 3'd3,
        MODE_HEX2   = 3'd4,
        MODE_HEX3   = 3'd5,
        MODE_HALT   = 3'd6
    } mode_t;

    typedef logic [2:0] status_t;

    localparam status_t ST_OK     = 3'd0;
    localparam status_t ST_TRAIL  = 3'd1;
    localparam status_t ST_BADHEX = 3'd2;
    localparam status_t ST_TRUNC  = 3'd3;
    localparam status_t ST_OVF    = 3'd4;

    localparam int CAP_W = 17;
    localparam logic [CAP_W-1:0] CAP_RESET = 17'h10000;

    // One queued request: up to three result bytes from a single input byte
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      cnt;     // results in this request, 1..3
        logic            bval;    // 0 for a bare end marker
        logic            done;
        status_t         status;
    } job_t;

    // {valid, value}
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c inside {[8'h30:8'h39]}) begin
            r = {1'b1, c[3:0]};
        end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

// ----- design/jsu_queue.sv -----
module jsu_queue
    import jsu_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output job_t head,
    output logic empty,
    output logic full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    job_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == FULL_CNT);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ----- design/jsu_front.sv -----
module jsu_front
    import jsu_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,
    input  logic             s_tlast,
    input  logic             cfg_valid,
    input  logic [CAP_W-1:0] cfg_data,
    input  logic             q_full,
    output logic             push,
    output job_t             push_job
);

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CR        = 8'h0D;
    localparam logic [7:0] LF        = 8'h0A;
    localparam logic [7:0] BS        = 8'h08;
    localparam logic [7:0] TAB       = 8'h09;
    localparam logic [7:0] FF        = 8'h0C;
    localparam logic [7:0] CONT_MARK = 8'h80;
    localparam logic [7:0] LEAD2     = 8'hC0;
    localparam logic [7:0] LEAD3     = 8'hE0;
    localparam logic [15:0] TWO_BYTE_LIMIT = 16'h0800;

    mode_t            mode_reg, mode_next;
    logic [11:0]      hex_reg, hex_next;
    logic [CAP_W-1:0] count_reg, count_next;
    status_t          err_reg, err_next;
    logic [CAP_W-1:0] cap_reg;

    logic             accept;
    logic [4:0]       hv;
    logic [15:0]      code;
    logic [1:0]       nreq, kept;
    logic [2:0][7:0]  b;
    status_t          new_err;
    logic [CAP_W-1:0] room;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign hv       = hex_value(s_tdata);
    assign code     = {hex_reg, hv[3:0]};
    assign room     = cap_reg - count_reg;

    always_comb begin
        mode_next = mode_reg;
        hex_next  = hex_reg;
        nreq      = 2'd0;
        b         = '0;
        new_err   = ST_OK;
        case (mode_reg)
            MODE_NORMAL: begin
                if (s_tdata == 8'h00) begin
                    mode_next = MODE_HALT;
                end else if (s_tdata == CH_BSLASH) begin
                    mode_next = MODE_ESC;
                    if (s_tlast) new_err = ST_TRAIL;
                end else begin
                    nreq = 2'd1;
                    b[0] = s_tdata;
                end
            end
            MODE_ESC: begin
                mode_next = MODE_NORMAL;
                nreq      = 2'd1;
                case (s_tdata)
                    CH_QUOTE: begin
                        nreq = 2'd2;
                        b[0] = CH_BSLASH;
                        b[1] = CH_QUOTE;
                    end
                    CH_R: b[0] = CR;
                    CH_N: b[0] = LF;
                    CH_B: b[0] = BS;
                    CH_T: b[0] = TAB;
                    CH_F: b[0] = FF;
                    CH_U: begin
                        nreq      = 2'd0;
                        mode_next = MODE_HEX0;
                        hex_next  = '0;
                        if (s_tlast) new_err = ST_TRUNC;
                    end
                    default: b[0] = s_tdata;
                endcase
            end
            MODE_HEX0, MODE_HEX1, MODE_HEX2: begin
                if (!hv[4]) begin
                    new_err   = ST_BADHEX;
                    mode_next = MODE_HALT;
                end else begin
                    hex_next  = {hex_reg[7:0], hv[3:0]};
                    mode_next = mode_t'(mode_reg + 3'd1);
                    if (s_tlast) new_err = ST_TRUNC;
                end
            end
            MODE_HEX3: begin
                if (!hv[4]) begin
                    new_err   = ST_BADHEX;
                    mode_next = MODE_HALT;
                end else begin
                    hex_next  = '0;
                    mode_next = MODE_NORMAL;
                    if (code < 16'(CONT_MARK)) begin
                        nreq = 2'd1;
                        b[0] = code[7:0];
                    end else if (code < TWO_BYTE_LIMIT) begin
                        nreq = 2'd2;
                        b[0] = LEAD2 | {3'b000, code[10:6]};
                        b[1] = CONT_MARK | {2'b00, code[5:0]};
                    end else begin
                        nreq = 2'd3;
                        b[0] = LEAD3 | {4'b0000, code[15:12]};
                        b[1] = CONT_MARK | {2'b00, code[11:6]};
                        b[2] = CONT_MARK | {2'b00, code[5:0]};
                    end
                end
            end
            default: ;  // halted until end of string
        endcase
    end

    // bytes beyond the capacity are dropped from the tail of the request
    always_comb begin
        if (count_reg >= cap_reg) begin
            kept = 2'd0;
        end else if (room >= CAP_W'(nreq)) begin
            kept = nreq;
        end else begin
            kept = room[1:0];
        end
        if (err_reg != ST_OK) begin
            err_next = err_reg;
        end else if (kept != nreq) begin
            err_next = ST_OVF;
        end else begin
            err_next = new_err;
        end
        count_next = count_reg + CAP_W'(kept);
    end

    always_comb begin
        push            = accept && ((kept != 2'd0) || s_tlast);
        push_job.bytes  = (kept == 2'd0) ? '0 : b;
        push_job.cnt    = (kept == 2'd0) ? 2'd1 : kept;
        push_job.bval   = (kept != 2'd0);
        push_job.done   = s_tlast;
        push_job.status = err_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_NORMAL;
            hex_reg   <= '0;
            count_reg <= '0;
            err_reg   <= ST_OK;
        end else if (accept) begin
            if (s_tlast) begin
                mode_reg  <= MODE_NORMAL;
                hex_reg   <= '0;
                count_reg <= '0;
                err_reg   <= ST_OK;
            end else begin
                mode_reg  <= mode_next;
                hex_reg   <= hex_next;
                count_reg <= count_next;
                err_reg   <= err_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAP_RESET;
        end else if (cfg_valid) begin
            cap_reg <= cfg_data;
        end
    end

endmodule

// ----- design/jsu_back.sv -----
module jsu_back
    import jsu_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  job_t        head,
    input  logic        q_empty,
    output logic        pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,
    output logic        m_tlast,
    output logic        m_tuser
);

    logic [1:0] idx_reg, idx_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic [7:0] byte_reg;
    status_t    status_reg;
    logic       last_reg;
    logic       bval_reg;
    logic       load;
    logic       final_part;

    assign load       = !q_empty && (!m_tvalid_reg || m_tready);
    assign final_part = (idx_reg == head.cnt - 2'd1);
    assign pop        = load && final_part;

    always_comb begin
        idx_next      = idx_reg;
        m_tvalid_next = m_tvalid_reg;
        if (load) begin
            idx_next      = final_part ? 2'd0 : idx_reg + 2'd1;
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg      <= 2'd0;
            m_tvalid_reg <= 1'b0;
        end else begin
            idx_reg      <= idx_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg   <= head.bytes[idx_reg];
            status_reg <= head.status;
            last_reg   <= head.done && final_part;
            bval_reg   <= head.bval;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'b00000, status_reg, byte_reg};
    assign m_tlast  = last_reg;
    assign m_tuser  = bval_reg;

endmodule

// ----- design/json_string_unescape_utf8.sv -----
// JSON string unescaper with UTF-8 output. Source bytes of one string arrive on s_ with
// tlast on the final byte; decoded bytes leave on m_, status in tdata[10:8] and tuser low
// for a bare end marker. A front stage decodes one byte per cycle while the queue has room
// and queues up to three result bytes as one request; a back stage sends one result per
// cycle, unless m_tready holds it, from the queue of QUEUE_DEPTH requests into an output
// register. An item is taken every cycle while the queue has room, so the sustained rate is
// one item per cycle when each item gives at most one result and m_tready stays high; an item
// giving more than one result (a \u escape can give three) makes the output port the limit.
// cfg_data sets the per-string byte capacity and is always ready.
module json_string_unescape_utf8
    import jsu_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // [7:0] in_byte
    input  logic             s_tlast,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [15:0]      m_tdata,   // [7:0] out_byte, [10:8] status, rest zero
    output logic             m_tlast,
    output logic             m_tuser,   // [0] byte_valid
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CAP_W-1:0] cfg_data
);

    logic push, pop, q_empty, q_full;
    job_t push_job, head;

    assign cfg_ready = 1'b1;

    jsu_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .push      (push),
        .push_job  (push_job)
    );

    jsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .empty    (q_empty),
        .full     (q_full)
    );

    jsu_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .q_empty  (q_empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

// ----- design/jsu_checker.sv -----
module jsu_checker
    import jsu_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast,
    input logic        m_tuser
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
            && $stable(m_tuser))
        else $error("result changed while stalled");

    // a bare end marker only closes a string and carries no byte
    a_bare_marker: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tlast && (m_tdata[7:0] == 8'h00))
        else $error("bare marker without end of string");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[10:8] <= ST_OVF) && (m_tdata[15:11] == 5'd0))
        else $error("bad status code");

    // once reported, an error stays until the string closes
    a_err_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast && (m_tdata[10:8] != ST_OK) ##1
            (m_tvalid && m_tready) |-> (m_tdata[10:8] == $past(m_tdata[10:8]))
            || !$past(m_tvalid && m_tready, 1))
        else $error("error status changed within a string");

    a_no_out_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result after reset");

endmodule

bind json_string_unescape_utf8 jsu_checker u_jsu_checker (.*);

// ----- test/tb_json_string_unescape_utf8.sv -----
`timescale 1ns / 100ps

module tb_json_string_unescape_utf8;
    import jsu_pkg::*;

    localparam logic [7:0] BSL         = 8'h5C;
    localparam int         QUIET_LIMIT = 2000;
    localparam int         PHASE_ITEMS = 28;
    localparam int         NUM_PHASES  = 6;

    typedef struct packed {
        logic [7:0] b;
        logic       last;
    } src_byte_t;

    typedef struct packed {
        logic [7:0] b;
        logic       bval;
        logic       done;
        status_t    st;
    } dec_byte_t;

    logic             aclk      = 1'b0;
    logic             aresetn   = 1'b0;
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    logic [7:0]       s_tdata   = 8'h00;
    logic             s_tlast   = 1'b0;
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    logic [15:0]      m_tdata;
    logic             m_tlast;
    logic             m_tuser;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CAP_W-1:0] cfg_data  = '0;

    src_byte_t  src_q[$];
    dec_byte_t  decoded_q[$];
    logic [7:0] fresh_bytes[$];
    logic [7:0] word_q[$];

    // decoder state as predicted
    mode_t            p_mode  = MODE_NORMAL;
    logic [11:0]      p_acc   = '0;
    logic [CAP_W-1:0] p_count = '0;
    logic [CAP_W-1:0] p_cap   = CAP_RESET;
    status_t          p_err   = ST_OK;

    int   sidle      = 0;
    int   rstall     = 0;
    int   mismatches = 0;
    int   quiet      = 0;
    logic s_taken    = 1'b0;
    logic cfg_taken  = 1'b0;

    always #5 aclk = ~aclk;

    json_string_unescape_utf8 DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("%0t mismatch: %s", $time, what);
    endtask

    task automatic note_error(input status_t code);
        if (p_err == ST_OK) begin
            p_err = code;
        end
    endtask

    task automatic keep_byte(input logic [7:0] b);
        if (p_count < p_cap) begin
            p_count = p_count + CAP_W'(1);
            fresh_bytes.push_back(b);
        end else begin
            note_error(ST_OVF);
        end
    endtask

    function automatic int nibble_of(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
        if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
        if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
        return -1;
    endfunction

    task automatic encode_code(input logic [15:0] code);
        if (code < 16'h0080) begin
            keep_byte(code[7:0]);
        end else if (code < 16'h0800) begin
            keep_byte(8'hC0 | {3'b000, code[10:6]});
            keep_byte(8'h80 | {2'b00, code[5:0]});
        end else begin
            keep_byte(8'hE0 | {4'b0000, code[15:12]});
            keep_byte(8'h80 | {2'b00, code[11:6]});
            keep_byte(8'h80 | {2'b00, code[5:0]});
        end
    endtask

    // Works out the results of one accepted source byte and queues them
    task automatic decode_byte(input logic [7:0] c, input logic last);
        int        d;
        dec_byte_t r;
        fresh_bytes.delete();
        case (p_mode)
            MODE_NORMAL: begin
                if (c == 8'h00) begin
                    p_mode = MODE_HALT;
                end else if (c == BSL) begin
                    p_mode = MODE_ESC;
                    if (last) note_error(ST_TRAIL);
                end else begin
                    keep_byte(c);
                end
            end
            MODE_ESC: begin
                p_mode = MODE_NORMAL;
                case (c)
                    8'h22: begin
                        keep_byte(BSL);
                        keep_byte(8'h22);
                    end
                    "r": keep_byte(8'h0D);
                    "n": keep_byte(8'h0A);
                    "b": keep_byte(8'h08);
                    "t": keep_byte(8'h09);
                    "f": keep_byte(8'h0C);
                    "u": begin
                        p_mode = MODE_HEX0;
                        p_acc  = '0;
                        if (last) note_error(ST_TRUNC);
                    end
                    default: keep_byte(c);
                endcase
            end
            MODE_HEX0, MODE_HEX1, MODE_HEX2, MODE_HEX3: begin
                d = nibble_of(c);
                if (d < 0) begin
                    note_error(ST_BADHEX);
                    p_mode = MODE_HALT;
                end else if (p_mode == MODE_HEX3) begin
                    encode_code({p_acc, d[3:0]});
                    p_acc  = '0;
                    p_mode = MODE_NORMAL;
                end else begin
                    p_acc  = {p_acc[7:0], d[3:0]};
                    p_mode = mode_t'(p_mode + 1);
                    if (last) note_error(ST_TRUNC);
                end
            end
            default: ; // halted: byte dropped
        endcase

        // status is the one at the end of the step, on every byte of it
        foreach (fresh_bytes[i]) begin
            decoded_q.push_back('{fresh_bytes[i], 1'b1, 1'b0, p_err});
        end
        if (last) begin
            if (fresh_bytes.size() == 0) begin
                decoded_q.push_back('{8'h00, 1'b0, 1'b1, p_err});
            end else begin
                r = decoded_q.pop_back();
                r.done = 1'b1;
                decoded_q.push_back(r);
            end
            p_mode  = MODE_NORMAL;
            p_acc   = '0;
            p_count = '0;
            p_err   = ST_OK;
        end
    endtask

    // monitor: predicts on each input request, checks each output request
    always @(posedge aclk) begin
        dec_byte_t want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) p_cap = cfg_data;
            if (s_tvalid && s_tready) decode_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                if (decoded_q.size() == 0) begin
                    report_mismatch($sformatf("unpredicted result, byte %02h", m_tdata[7:0]));
                end else begin
                    want = decoded_q.pop_front();
                    if (m_tdata[7:0] !== want.b)
                        report_mismatch($sformatf("out_byte %02h, predicted %02h",
                                                  m_tdata[7:0], want.b));
                    if (m_tdata[10:8] !== want.st)
                        report_mismatch($sformatf("status %0d, predicted %0d",
                                                  m_tdata[10:8], want.st));
                    if (m_tuser !== want.bval)
                        report_mismatch($sformatf("byte_valid %b, predicted %b",
                                                  m_tuser, want.bval));
                    if (m_tlast !== want.done)
                        report_mismatch($sformatf("string_done %b, predicted %b",
                                                  m_tlast, want.done));
                end
            end
        end
        s_taken   <= aresetn && s_tvalid && s_tready;
        cfg_taken <= aresetn && cfg_valid && cfg_ready;
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            quiet <= 0;
        end else if (quiet == QUIET_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // driver
    always @(negedge aclk) begin
        src_byte_t it;
        if (aresetn && (!s_tvalid || s_taken)) begin
            if (src_q.size() != 0 && $urandom_range(0, 99) >= sidle) begin
                it = src_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= it.b;
                s_tlast  <= it.last;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        m_tready <= aresetn && ($urandom_range(0, 99) >= rstall);
    end

    task automatic put(input logic [7:0] b, input logic last);
        src_q.push_back('{b, last});
    endtask

    task automatic flush_string();
        foreach (word_q[i]) begin
            put(word_q[i], i == word_q.size() - 1);
        end
        word_q.delete();
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
        if (n < 4'd10) return 8'h30 + {4'b0000, n};
        return (upper ? 8'h41 : 8'h61) + {4'b0000, n} - 8'd10;
    endfunction

    task automatic add_unicode(input logic [15:0] code, input int ndigits);
        word_q.push_back(BSL);
        word_q.push_back("u");
        for (int k = 0; k < ndigits; k++) begin
            word_q.push_back(hex_char(code[15 - 4 * k -: 4], $urandom_range(0, 1)));
        end
    endtask

    task automatic add_token();
        int         kind;
        logic [7:0] c;
        logic [15:0] code;
        kind = $urandom_range(0, 9);
        if (kind < 5) begin
            c = 8'($urandom_range(1, 255));
            if (c == BSL) c = 8'h5B;
            word_q.push_back(c);
        end else if (kind < 8) begin
            case ($urandom_range(0, 10))
                0: c = 8'h22;
                1: c = "r";
                2: c = "n";
                3: c = "b";
                4: c = "t";
                5: c = "f";
                6: c = BSL;
                7: c = 8'h2F;
                8: c = 8'h00;
                default: begin
                    do c = 8'($urandom_range(0, 255)); while (c == "u");
                end
            endcase
            word_q.push_back(BSL);
            word_q.push_back(c);
        end else begin
            case ($urandom_range(0, 2))
                0:       code = 16'($urandom_range(0, 16'h007F));
                1:       code = 16'($urandom_range(16'h0080, 16'h07FF));
                default: code = 16'($urandom_range(16'h0800, 16'hFFFF));
            endcase
            add_unicode(code, 4);
        end
    endtask

    task automatic gen_string();
        int         pick;
        int         n;
        logic [7:0] c;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            n = $urandom_range(1, 6);
            repeat (n) add_token();
        end else if (pick < 90) begin
            n = $urandom_range(0, 3);
            repeat (n) add_token();
            case ($urandom_range(0, 3))
                0: word_q.push_back(BSL);
                1: add_unicode(16'($urandom_range(0, 16'hFFFF)), $urandom_range(0, 3));
                2: begin
                    add_unicode(16'($urandom_range(0, 16'hFFFF)), $urandom_range(0, 3));
                    do c = 8'($urandom_range(0, 255)); while (nibble_of(c) >= 0);
                    word_q.push_back(c);
                end
                default: word_q.push_back(8'h00);
            endcase
            // anything after a halt is dropped by the block
            if (word_q[$] != BSL && nibble_of(word_q[$]) < 0) begin
                n = $urandom_range(0, 2);
                repeat (n) word_q.push_back(8'($urandom_range(0, 255)));
            end
        end else begin
            n = $urandom_range(1, 6);
            repeat (n) word_q.push_back(8'($urandom_range(0, 255)));
        end
        flush_string();
    endtask

    task automatic wait_drained();
        do @(posedge aclk); while (src_q.size() != 0 || s_tvalid || decoded_q.size() != 0);
        repeat (6) @(posedge aclk);
    endtask

    task automatic set_capacity(input logic [CAP_W-1:0] v);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(negedge aclk); while (!cfg_taken);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [CAP_W-1:0] cap;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed strings at the reset capacity
        put("A", 1'b0);  put(8'hFF, 1'b1);
        put(BSL, 1'b0);  put("u", 1'b0);
        put("0", 1'b0);  put("0", 1'b0); put("0", 1'b0); put("0", 1'b1);
        put(BSL, 1'b0);  put("u", 1'b0);
        put("F", 1'b0);  put("f", 1'b0); put("F", 1'b0); put("f", 1'b1);
        put(BSL, 1'b1);                                   // trailing escape
        put(BSL, 1'b0);  put("u", 1'b0); put("1", 1'b0); put("2", 1'b1);
        put(BSL, 1'b0);  put("u", 1'b0); put("G", 1'b0); put("x", 1'b1);
        put(8'h00, 1'b0); put("a", 1'b1);                 // plain NUL halts
        wait_drained();

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0:       cap = CAP_W'(1);
                1:       cap = CAP_W'(3);
                3:       cap = CAP_W'($urandom_range(2, 12));
                4:       cap = CAP_W'(2);
                default: cap = CAP_RESET;
            endcase
            set_capacity(cap);
            case (p % 4)
                0:       begin sidle = 46; rstall = 0;  end
                1:       begin sidle = 0;  rstall = 46; end
                2:       begin sidle = 24; rstall = 24; end
                default: begin sidle = 0;  rstall = 0;  end
            endcase
            while (src_q.size() < PHASE_ITEMS) gen_string();
            wait_drained();
        end

        repeat (8) @(posedge aclk);
        if (mismatches == 0 && decoded_q.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
